>>> hdl/bci_pkg.sv
`default_nettype none
package bci_pkg;

  localparam int unsigned ADDR_BITS = 12;
  localparam int unsigned DATA_BITS = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_STEP  = 2'd3
  } cmd_e;

  localparam logic [2:0] OP_AND = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_LDA = 3'd2;
  localparam logic [2:0] OP_STA = 3'd3;
  localparam logic [2:0] OP_BUN = 3'd4;
  localparam logic [2:0] OP_BSA = 3'd5;
  localparam logic [2:0] OP_ISZ = 3'd6;
  localparam logic [2:0] OP_REG = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] address;
    logic [15:0] data;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [11:0] pc_value;
    logic [15:0] acc_value;
    logic        link_bit;
    logic        running;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_mem;   // write zero at sweep address
    logic cap_req;   // capture request
    logic mem_wr;    // write command data
    logic rd_cmd;    // read command address
    logic rd_pc;     // fetch read
    logic rd_ea;     // read at effective address
    logic ld_ir;     // capture instruction, pc+1
    logic ld_ind;    // capture indirect address
    logic exec;      // execute with operand
    logic set_pc;    // start command
    logic rsp;       // issue result
    logic rsp_rd;    // result carries read data
  } ctl_t;

  typedef struct packed {
    logic       run;
    logic [1:0] cmd;
    logic [2:0] op;
    logic       ind;
    logic       sweep_done;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/bci_datapath.sv
`default_nettype none
module bci_datapath import bci_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire ctl_t ctl_i,
  output sts_t      sts_o,
  output logic      done_o,
  output rsp_t      rsp_o
);
  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [DATA_BITS-1:0] mem [MEM_WORDS];
  logic [DATA_BITS-1:0] rdata_q;
  logic [AW-1:0]        sweep_q;
  logic                 sweep_done_q;
  req_t                 req_q;
  logic [11:0]          pc_q, ea_q;
  logic [15:0]          acc_q;
  logic [3:0]           ir_q;
  logic                 link_q, run_q, done_q;
  rsp_t                 rsp_q;

  logic [AW-1:0] raddr, waddr;
  logic [15:0]   wdata;
  logic          we;
  logic [15:0]   acc_d;
  logic [11:0]   pc_d;
  logic          link_d, run_d;
  logic [12:0]   sum;
  logic [15:0]   inc;
  logic [11:0]   pc_inc;

  // 12-bit address folded into the memory depth by constant compare and subtract (MEM_WORDS of 256 or more)
  function automatic logic [AW-1:0] mem_idx(logic [11:0] a);
    logic [15:0] r;
    r = {4'd0, a};
    for (int k = 3; k >= 0; k--) begin
      if (r >= 16'(MEM_WORDS << k)) r = r - 16'(MEM_WORDS << k);
    end
    return r[AW-1:0];
  endfunction

  // Memory address and write selection
  always_comb begin
    raddr = mem_idx(req_q.address);
    if (ctl_i.rd_pc) raddr = mem_idx(pc_q);
    else if (ctl_i.rd_ea) raddr = mem_idx(ea_q);
    else if (ctl_i.rd_cmd) raddr = mem_idx(req_q.address);
    we = 1'b0; waddr = sweep_q; wdata = '0;
    if (ctl_i.clr_mem) begin
      we = 1'b1;
    end else if (ctl_i.mem_wr) begin
      we = 1'b1; waddr = mem_idx(req_q.address); wdata = req_q.data;
    end else if (ctl_i.exec && !run_q) begin
      we = 1'b0;
    end else if (ctl_i.exec) begin
      waddr = mem_idx(ea_q);
      case (ir_q[2:0])
        OP_STA: begin we = 1'b1; wdata = acc_q; end
        OP_BSA: begin we = 1'b1; wdata = {4'd0, pc_q}; end
        OP_ISZ: begin we = 1'b1; wdata = rdata_q + 16'd1; end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Execute logic
  always_comb begin
    acc_d = acc_q; pc_d = pc_q; link_d = link_q; run_d = run_q;
    sum = {1'b0, acc_q[11:0]} + {1'b0, rdata_q[11:0]};
    inc = rdata_q + 16'd1;
    pc_inc = pc_q + 12'd1;
    if (ctl_i.set_pc) begin
      pc_d = req_q.address; run_d = 1'b1;
    end else if (ctl_i.ld_ir) begin
      pc_d = pc_inc;
    end else if (ctl_i.exec) begin
      case (ir_q[2:0])
        OP_AND: acc_d = acc_q & rdata_q;
        OP_ADD: begin link_d = sum[12]; acc_d = {acc_q[15:12], sum[11:0]}; end
        OP_LDA: acc_d = rdata_q;
        OP_BUN: pc_d = ea_q;
        OP_BSA: pc_d = ea_q + 12'd1;
        OP_ISZ: if (inc == 16'd0) pc_d = pc_inc;
        OP_REG: begin
          if (ea_q[11]) acc_d = '0;
          else if (ea_q[10]) link_d = 1'b0;
          else if (ea_q[9]) acc_d = ~acc_q;
          else if (ea_q[8]) link_d = ~link_q;
          else if (ea_q[7]) begin acc_d = {link_q, acc_q[15:1]}; link_d = acc_q[0]; end
          else if (ea_q[6]) begin acc_d = {acc_q[14:0], link_q}; link_d = acc_q[15]; end
          else if (ea_q[5]) acc_d = acc_q + 16'd1;
          else if (ea_q[4]) begin if (!acc_q[15]) pc_d = pc_inc; end
          else if (ea_q[3]) begin if (acc_q[15]) pc_d = pc_inc; end
          else if (ea_q[2]) begin if (acc_q == 16'd0) pc_d = pc_inc; end
          else if (ea_q[1]) begin if (!link_q) pc_d = pc_inc; end
          else if (ea_q[0]) run_d = 1'b0;
        end
        default: acc_d = acc_q;
      endcase
    end
  end

  // Architectural state and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; acc_q <= '0; link_q <= 1'b0; run_q <= 1'b0;
      sweep_q <= '0; sweep_done_q <= 1'b0; done_q <= 1'b0; ir_q <= '0;
    end else begin
      pc_q <= pc_d; acc_q <= acc_d; link_q <= link_d; run_q <= run_d;
      done_q <= ctl_i.rsp;
      if (ctl_i.clr_mem) begin
        sweep_q <= sweep_q + 1'b1;
        if (sweep_q == AW'(MEM_WORDS - 1)) sweep_done_q <= 1'b1;
      end
      if (ctl_i.ld_ir) ir_q <= {rdata_q[15], rdata_q[14:12]};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_req) req_q <= req_i;
    if (ctl_i.ld_ir) ea_q <= rdata_q[11:0];
    else if (ctl_i.ld_ind) ea_q <= rdata_q[11:0];
    if (ctl_i.rsp) begin
      rsp_q.read_data <= ctl_i.rsp_rd ? rdata_q : '0;
      rsp_q.pc_value  <= pc_d;
      rsp_q.acc_value <= acc_d;
      rsp_q.link_bit  <= link_d;
      rsp_q.running   <= run_d;
    end
  end

  assign sts_o.run        = run_q;
  assign sts_o.cmd        = req_q.cmd;
  assign sts_o.op         = ir_q[2:0];
  assign sts_o.ind        = ir_q[3];
  assign sts_o.sweep_done = sweep_done_q;
  assign done_o           = done_q;
  assign rsp_o            = rsp_q;

  ap_sweep_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr_mem |-> !ctl_i.rsp) else $error("result during clear");
  ap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rsp |=> done_q) else $error("strobe lost");
  ap_one_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.clr_mem && ctl_i.mem_wr)) else $error("write conflict");
endmodule
`default_nettype wire

>>> hdl/bci_control.sv
`default_nettype none
module bci_control import bci_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output logic      busy_o,
  output ctl_t      ctl_o
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_IND   = 3'd5;
  localparam logic [2:0] S_OPRD  = 3'd6;
  localparam logic [2:0] S_EXEC  = 3'd7;

  logic [2:0] state_q, state_d;

  // Sequencer
  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr_mem = 1'b1;
        if (sts_i.sweep_done) begin ctl_o.clr_mem = 1'b0; state_d = S_IDLE; end
      end
      S_IDLE: if (start_i) begin ctl_o.cap_req = 1'b1; state_d = S_DISP; end
      S_DISP: begin
        case (sts_i.cmd)
          CMD_WRITE: begin ctl_o.mem_wr = 1'b1; ctl_o.rsp = 1'b1; state_d = S_IDLE; end
          CMD_READ:  begin ctl_o.rd_cmd = 1'b1; state_d = S_EXEC; end
          CMD_START: begin ctl_o.set_pc = 1'b1; ctl_o.rsp = 1'b1; state_d = S_IDLE; end
          default: begin
            if (sts_i.run) begin ctl_o.rd_pc = 1'b1; state_d = S_FETCH; end
            else begin ctl_o.rsp = 1'b1; state_d = S_IDLE; end
          end
        endcase
      end
      S_FETCH: begin ctl_o.ld_ir = 1'b1; state_d = S_DEC; end
      S_DEC: begin
        if (sts_i.op == OP_REG) begin
          ctl_o.exec = 1'b1; ctl_o.rsp = 1'b1; state_d = S_IDLE;
        end else begin
          ctl_o.rd_ea = 1'b1;
          state_d = sts_i.ind ? S_IND : S_EXEC;
        end
      end
      S_IND: begin ctl_o.ld_ind = 1'b1; state_d = S_OPRD; end
      S_OPRD: begin ctl_o.rd_ea = 1'b1; state_d = S_EXEC; end
      S_EXEC: begin
        ctl_o.rsp = 1'b1;
        if (sts_i.cmd == CMD_READ) ctl_o.rsp_rd = 1'b1;
        else ctl_o.exec = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

  ap_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q == S_DISP) else $error("accept lost");
  ap_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rsp |=> state_q == S_IDLE) else $error("result not final");
  ap_ind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IND |=> state_q == S_OPRD) else $error("indirect order");
endmodule
`default_nettype wire

>>> hdl/basic_computer_instruction_core.sv
`default_nettype none
// States from accept to result: write/start/halted step DISP; read DISP, EXEC;
// register op DISP, FETCH, DEC; memory op DISP, FETCH, DEC, EXEC, indirect
// adding IND, OPRD before EXEC. One command at a time, the single memory read
// port sets the steps; busy falls as the strobe appears, so the next command is
// taken at the edge ending it. Results cannot be stalled. Reset: state cleared
// at once; memory is then zeroed over all MEM_WORDS words, busy high during it.
module basic_computer_instruction_core import bci_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096,
  parameter int unsigned WORD_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);
  ctl_t ctl;
  sts_t sts;
  logic busy_c;

  bci_control u_ctl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .busy_o(busy_c), .ctl_o(ctl)
  );

  bci_datapath #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk_i, .rst_ni, .req_i, .ctl_i(ctl), .sts_o(sts), .done_o, .rsp_o
  );

  assign busy = busy_c | (WORD_BITS != DATA_BITS);
endmodule
`default_nettype wire
